// ===== rtl/rqb_pkg.sv =====
`default_nettype none
package rqb_pkg;

  typedef enum logic [1:0] {
    KIND_POLL = 2'd0,
    KIND_ENQ  = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_FAIL = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [0:0] CFG_BASE = 1'b0;
  localparam logic [0:0] CFG_MAX  = 1'b1;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item, clear the scan results
    logic search;    // compare the entry at the scan pointer with the id
    logic shift;     // copy entry ptr+1 into entry ptr
    logic drop_last; // decrement the count after compaction
    logic fail_upd;  // update backoff of the found entry
    logic enq;       // append a new entry
    logic scan;      // look for the oldest due entry
    logic ptr_clr;   // reset the scan pointer
    logic ptr_inc;   // advance the scan pointer
    logic emit;      // drive a result
  } rqb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_last;  // pointer has reached count (end of held entries)
    logic shift_end; // pointer+1 has reached count
    logic hit;       // entry at pointer matches the id
    logic full;
  } rqb_sts_t;

endpackage
`default_nettype wire

// ===== rtl/retry_queue_with_backoff.sv =====
// Channel  | handshake              | fields
// command  | start_i, busy_o        | kind_i now_ms_i entry_id_i tag_i payload_ref_i wall_time_ns_i
// result   | done_o (one cycle)     | status_o assigned_id_o count_o ready_*_o
// config   | cfg_we_i               | cfg_idx_i cfg_data_i
//
// After the start transfer busy_o stays high longest on an enqueue into a full queue: a
// pointer walk or search over the held entries, an optional compaction sweep, then a
// scan for the oldest due entry, one entry per cycle.
// The result follows in the next cycle, when busy_o is already low again.
// Reset clears the queue count and the id counter; entry storage is not cleared.
// Command inputs are sampled only at the start transfer; results cannot be stalled.
`default_nettype none
module retry_queue_with_backoff #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] entry_id_i,
  input  wire logic [15:0] tag_i,
  input  wire logic [31:0] payload_ref_i,
  input  wire logic [62:0] wall_time_ns_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [31:0]      assigned_id_o,
  output logic [10:0]      count_o,
  output logic             ready_valid_o,
  output logic [31:0]      ready_id_o,
  output logic [15:0]      ready_tag_o,
  output logic [31:0]      ready_payload_ref_o,
  output logic [62:0]      ready_enqueued_ns_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rqb_pkg::rqb_cmd_t cmd;
  rqb_pkg::rqb_sts_t sts;
  logic [31:0] base_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd1000;
      max_q  <= 32'd60000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rqb_pkg::CFG_BASE) begin
        base_q <= cfg_data_i;
      end else begin
        max_q <= cfg_data_i;
      end
    end
  end

  rqb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  rqb_datapath #(.DEPTH(DEPTH), .PW(PW), .CW(CW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .now_ms_i, .entry_id_i, .tag_i, .payload_ref_i, .wall_time_ns_i,
    .base_q_i(base_q), .max_q_i(max_q),
    .done_o, .status_o, .assigned_id_o, .count_o, .ready_valid_o,
    .ready_id_o, .ready_tag_o, .ready_payload_ref_o, .ready_enqueued_ns_o
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= 11'(DEPTH)) else $error("count exceeds depth");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(start_i && !busy_o)) else $error("result too early");
  a_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ready_valid_o) |-> (ready_id_o == 32'd0)) else $error("stale ready id");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == rqb_pkg::STATUS_FULL) |-> (count_o == 11'(DEPTH)))
    else $error("full without full count");

endmodule
`default_nettype wire

// ===== rtl/rqb_datapath.sv =====
`default_nettype none
module rqb_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PW = 4,
  parameter int unsigned CW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rqb_pkg::rqb_cmd_t cmd_i,
  output rqb_pkg::rqb_sts_t    sts_o,
  input  wire logic [47:0]     now_ms_i,
  input  wire logic [31:0]     entry_id_i,
  input  wire logic [15:0]     tag_i,
  input  wire logic [31:0]     payload_ref_i,
  input  wire logic [62:0]     wall_time_ns_i,
  input  wire logic [31:0]     base_q_i,
  input  wire logic [31:0]     max_q_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [31:0]          assigned_id_o,
  output logic [10:0]          count_o,
  output logic                 ready_valid_o,
  output logic [31:0]          ready_id_o,
  output logic [15:0]          ready_tag_o,
  output logic [31:0]          ready_payload_ref_o,
  output logic [62:0]          ready_enqueued_ns_o
);

  logic [31:0] id_mem [DEPTH];
  logic [15:0] tag_mem [DEPTH];
  logic [31:0] pay_mem [DEPTH];
  logic [62:0] enq_mem [DEPTH];
  logic [31:0] bo_mem [DEPTH];
  logic [47:0] nxt_mem [DEPTH];

  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  logic [31:0]   seq_q;
  logic [47:0]   now_q;
  logic [31:0]   eid_q;
  logic [15:0]   tag_q;
  logic [31:0]   pay_q;
  logic [62:0]   wall_q;
  logic [1:0]    status_q;
  logic [31:0]   assigned_q;
  logic          rv_q;
  logic [PW-1:0] rsel_q;
  logic [PW-1:0] pidx;
  logic [PW-1:0] pidx1;
  logic [CW:0]   ptr_p1;
  logic [32:0]   dbl;
  logic [31:0]   new_bo;
  logic [48:0]   tsum;

  assign pidx   = ptr_q[PW-1:0];
  assign ptr_p1 = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
  assign pidx1  = ptr_p1[PW-1:0];

  assign sts_o.ptr_last  = (ptr_q >= count_q);
  assign sts_o.shift_end = (ptr_p1 >= {1'b0, count_q});
  assign sts_o.hit       = (id_mem[pidx] == eid_q);
  assign sts_o.full      = (count_q == CW'(DEPTH));

  always_comb begin
    dbl = {bo_mem[pidx], 1'b0};
    if (bo_mem[pidx] == 32'd0) begin
      new_bo = base_q_i;
    end else if (dbl > {1'b0, max_q_i}) begin
      new_bo = max_q_i;
    end else begin
      new_bo = dbl[31:0];
    end
    tsum = {1'b0, now_q} + {17'd0, new_bo};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      id_mem[pidx]  <= id_mem[pidx1];
      tag_mem[pidx] <= tag_mem[pidx1];
      pay_mem[pidx] <= pay_mem[pidx1];
      enq_mem[pidx] <= enq_mem[pidx1];
      bo_mem[pidx]  <= bo_mem[pidx1];
      nxt_mem[pidx] <= nxt_mem[pidx1];
    end else if (cmd_i.fail_upd) begin
      bo_mem[pidx]  <= new_bo;
      nxt_mem[pidx] <= tsum[48] ? rqb_pkg::TIME_MAX : tsum[47:0];
    end else if (cmd_i.enq && !sts_o.full) begin
      // Enqueue writes at the count, so the pointer is parked there first.
      id_mem[pidx]  <= seq_q;
      tag_mem[pidx] <= tag_q;
      pay_mem[pidx] <= pay_q;
      enq_mem[pidx] <= wall_q;
      bo_mem[pidx]  <= 32'd0;
      nxt_mem[pidx] <= 48'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      seq_q      <= '0;
      now_q      <= '0;
      eid_q      <= '0;
      tag_q      <= '0;
      pay_q      <= '0;
      wall_q     <= '0;
      status_q   <= rqb_pkg::STATUS_OK;
      assigned_q <= '0;
      rv_q       <= 1'b0;
      rsel_q     <= '0;
      done_o     <= 1'b0;
    end else begin
      done_o <= cmd_i.emit;
      if (cmd_i.load) begin
        now_q      <= now_ms_i;
        eid_q      <= entry_id_i;
        tag_q      <= tag_i;
        pay_q      <= payload_ref_i;
        wall_q     <= wall_time_ns_i;
        status_q   <= rqb_pkg::STATUS_OK;
        assigned_q <= '0;
        rv_q       <= 1'b0;
      end
      if (cmd_i.search && sts_o.ptr_last) begin
        status_q <= rqb_pkg::STATUS_UNKNOWN;
      end
      if (cmd_i.enq) begin
        if (sts_o.full) begin
          status_q <= rqb_pkg::STATUS_FULL;
        end else begin
          assigned_q <= seq_q;
          seq_q      <= seq_q + 32'd1;
          count_q    <= count_q + CW'(1);
        end
      end
      if (cmd_i.drop_last) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.scan && !rv_q && !sts_o.ptr_last && nxt_mem[pidx] <= now_q) begin
        rv_q   <= 1'b1;
        rsel_q <= pidx;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_p1[CW-1:0];
      end
    end
  end

  always_comb begin
    status_o            = status_q;
    assigned_id_o       = assigned_q;
    count_o             = 11'(count_q);
    ready_valid_o       = rv_q;
    ready_id_o          = rv_q ? id_mem[rsel_q] : 32'd0;
    ready_tag_o         = rv_q ? tag_mem[rsel_q] : 16'd0;
    ready_payload_ref_o = rv_q ? pay_mem[rsel_q] : 32'd0;
    ready_enqueued_ns_o = rv_q ? enq_mem[rsel_q] : 63'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/rqb_ctrl.sv =====
`default_nettype none
module rqb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        kind_i,
  input  wire rqb_pkg::rqb_sts_t sts_i,
  output rqb_pkg::rqb_cmd_t      cmd_o,
  output logic                   busy_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PARK   = 3'd3;
  localparam logic [2:0] S_ENQ    = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] kind_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          unique case (kind_i)
            rqb_pkg::KIND_POLL: state_d = S_SCAN;
            rqb_pkg::KIND_ENQ:  state_d = S_PARK;
            default:            state_d = S_SEARCH;
          endcase
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = S_SCAN;
        end else if (sts_i.hit) begin
          if (kind_q == rqb_pkg::KIND_FAIL) begin
            cmd_o.fail_upd = 1'b1;
            cmd_o.ptr_clr  = 1'b1;
            state_d = S_SCAN;
          end else begin
            state_d = S_SHIFT;
          end
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_end) begin
          cmd_o.drop_last = 1'b1;
          cmd_o.ptr_clr   = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.shift   = 1'b1;
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_PARK: begin
        // Walk the pointer up to the count, where the new entry goes.
        if (sts_i.ptr_last) begin
          state_d = S_ENQ;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_ENQ: begin
        cmd_o.enq     = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= rqb_pkg::KIND_POLL;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) begin
        kind_q <= kind_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/retry_queue_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module retry_queue_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [47:0] now_ms_i,
  input  wire logic [31:0] entry_id_i,
  input  wire logic [15:0] tag_i,
  input  wire logic [31:0] payload_ref_i,
  input  wire logic [62:0] wall_time_ns_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [31:0] assigned_id_i,
  input  wire logic [10:0] count_i,
  input  wire logic        ready_valid_i,
  input  wire logic [31:0] ready_id_i,
  input  wire logic [15:0] ready_tag_i,
  input  wire logic [31:0] ready_payload_ref_i,
  input  wire logic [62:0] ready_enqueued_ns_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic [10:0] count;
    logic        ready_valid;
    logic [31:0] ready_id;
    logic [15:0] ready_tag;
    logic [31:0] ready_payload_ref;
    logic [62:0] ready_enqueued_ns;
  } reply_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] tag;
    logic [31:0] payload;
    logic [62:0] enqueued;
    logic [31:0] backoff;
    logic [47:0] due_ms;
  } entry_t;

  entry_t      queue_q[$];
  reply_t      replies_q[$];
  logic [31:0] base_ms, max_ms, seq_id;

  function automatic reply_t apply_command(input logic [1:0] kind, input logic [47:0] now,
      input logic [31:0] id, input logic [15:0] tag, input logic [31:0] payload,
      input logic [62:0] wall);
    reply_t r;
    int     hit;
    logic [32:0] dbl;
    logic [48:0] sum;
    entry_t e;
    r = '0;
    hit = -1;
    if (kind != rqb_pkg::KIND_POLL && kind != rqb_pkg::KIND_ENQ) begin
      foreach (queue_q[i]) if (hit < 0 && queue_q[i].id == id) hit = i;
    end
    case (rqb_pkg::kind_e'(kind))
      rqb_pkg::KIND_ENQ: begin
        if (queue_q.size() >= DEPTH) begin
          r.status = rqb_pkg::STATUS_FULL;
        end else begin
          e = '{seq_id, tag, payload, wall, 32'd0, 48'd0};
          queue_q.insert(queue_q.size(), e);
          r.assigned_id = seq_id;
          seq_id++;
        end
      end
      rqb_pkg::KIND_ACK: begin
        if (hit < 0) r.status = rqb_pkg::STATUS_UNKNOWN;
        else queue_q.delete(hit);
      end
      rqb_pkg::KIND_FAIL: begin
        if (hit < 0) begin
          r.status = rqb_pkg::STATUS_UNKNOWN;
        end else begin
          if (queue_q[hit].backoff == 0) begin
            dbl = {1'b0, base_ms};
          end else begin
            dbl = {queue_q[hit].backoff, 1'b0};
            if (dbl > {1'b0, max_ms}) dbl = {1'b0, max_ms};
          end
          queue_q[hit].backoff = dbl[31:0];
          sum = {1'b0, now} + {17'd0, dbl[31:0]};
          queue_q[hit].due_ms = sum[48] ? rqb_pkg::TIME_MAX : sum[47:0];
        end
      end
      default: ;
    endcase
    r.count = 11'(queue_q.size());
    foreach (queue_q[i]) begin
      if (!r.ready_valid && queue_q[i].due_ms <= now) begin
        r.ready_valid = 1'b1;
        r.ready_id = queue_q[i].id;
        r.ready_tag = queue_q[i].tag;
        r.ready_payload_ref = queue_q[i].payload;
        r.ready_enqueued_ns = queue_q[i].enqueued;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      base_ms = 32'd1000;
      max_ms = 32'd60000;
      seq_id = '0;
      queue_q.delete();
      replies_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rqb_pkg::CFG_BASE) base_ms = cfg_data_i;
        else max_ms = cfg_data_i;
      end
      if (done_i) begin
        got = '{status_i, assigned_id_i, count_i, ready_valid_i, ready_id_i, ready_tag_i,
                ready_payload_ref_i, ready_enqueued_ns_i};
        if (replies_q.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          errors_o++;
        end else begin
          want = replies_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, want, got);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        replies_q.insert(replies_q.size(), apply_command(kind_i, now_ms_i, entry_id_i, tag_i,
                                                         payload_ref_i, wall_time_ns_i));
      end
      pending_o = replies_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== sim/retry_queue_with_backoff_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module retry_queue_with_backoff_test;

  localparam int unsigned DEPTH = 16;

  logic        clk, rst_n, start, cfg_we, cfg_idx, busy, done, ready_valid;
  logic [1:0]  kind, status;
  logic [47:0] now_ms;
  logic [31:0] entry_id, payload_ref, cfg_data, assigned_id, ready_id, ready_payload_ref;
  logic [15:0] tag, ready_tag;
  logic [62:0] wall_time_ns, ready_enqueued_ns;
  logic [10:0] count;
  int          errors, pending, idle_pct;
  logic [47:0] clock_ms;
  logic [31:0] id_hint;

  retry_queue_with_backoff #(.DEPTH(DEPTH)) i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .kind_i(kind),
    .now_ms_i(now_ms), .entry_id_i(entry_id), .tag_i(tag), .payload_ref_i(payload_ref),
    .wall_time_ns_i(wall_time_ns), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .done_o(done), .status_o(status), .assigned_id_o(assigned_id),
    .count_o(count), .ready_valid_o(ready_valid), .ready_id_o(ready_id),
    .ready_tag_o(ready_tag), .ready_payload_ref_o(ready_payload_ref),
    .ready_enqueued_ns_o(ready_enqueued_ns)
  );

  retry_queue_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .kind_i(kind),
    .now_ms_i(now_ms), .entry_id_i(entry_id), .tag_i(tag), .payload_ref_i(payload_ref),
    .wall_time_ns_i(wall_time_ns), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .done_i(done), .status_i(status), .assigned_id_i(assigned_id),
    .count_i(count), .ready_valid_i(ready_valid), .ready_id_i(ready_id),
    .ready_tag_i(ready_tag), .ready_payload_ref_i(ready_payload_ref),
    .ready_enqueued_ns_i(ready_enqueued_ns), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Issues one command and returns after the block has taken the transfer.
  task automatic issue(input rqb_pkg::kind_e k, input logic [47:0] t, input logic [31:0] id,
                       input logic [15:0] tg, input logic [31:0] pl, input logic [62:0] w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    kind <= k;
    now_ms <= t;
    entry_id <= id;
    tag <= tg;
    payload_ref <= pl;
    wall_time_ns <= w;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (3 * DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int n);
    logic [47:0] t;
    logic [31:0] id;
    int          r;
    repeat (n) begin
      r = $urandom_range(99);
      // Time mostly creeps forward so backoffs expire; sometimes it jumps anywhere.
      clock_ms = clock_ms + $urandom_range(3000);
      t = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom}) : clock_ms;
      if ($urandom_range(9) == 0) t = rqb_pkg::TIME_MAX - $urandom_range(100);
      // Ids mostly hit live entries near the counter.
      id = ($urandom_range(7) == 0) ? $urandom : id_hint - $urandom_range(20);
      if (r < 35) begin
        issue(rqb_pkg::KIND_ENQ, t, id, 16'($urandom), $urandom,
              63'({$urandom, $urandom}));
        id_hint++;
      end else if (r < 60) begin
        issue(rqb_pkg::KIND_ACK, t, id, 16'($urandom), $urandom,
              63'({$urandom, $urandom}));
      end else if (r < 90) begin
        issue(rqb_pkg::KIND_FAIL, t, id, 16'($urandom), $urandom,
              63'({$urandom, $urandom}));
      end else begin
        issue(rqb_pkg::KIND_POLL, t, id, 16'($urandom), $urandom,
              63'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    kind = rqb_pkg::KIND_POLL;
    now_ms = '0;
    entry_id = '0;
    tag = '0;
    payload_ref = '0;
    wall_time_ns = '0;
    cfg_we = 1'b0;
    cfg_idx = rqb_pkg::CFG_BASE;
    cfg_data = '0;
    idle_pct = 0;
    clock_ms = '0;
    id_hint = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: poll on empty, fill to full, unknown ids, backoff to the limit, saturation.
    issue(rqb_pkg::KIND_POLL, '0, '0, '0, '0, '0);
    issue(rqb_pkg::KIND_ACK, '0, 32'd5, '0, '0, '0);
    for (int i = 0; i <= DEPTH; i++) begin
      issue(rqb_pkg::KIND_ENQ, 48'd0, '0, i[0] ? 16'hFFFF : 16'h0, i[0] ? '1 : '0,
            i[0] ? '1 : '0);
    end
    id_hint = DEPTH;
    issue(rqb_pkg::KIND_FAIL, 48'd10, 32'd0, '0, '0, '0);
    repeat (8) issue(rqb_pkg::KIND_FAIL, 48'd100, 32'd1, '0, '0, '0);
    issue(rqb_pkg::KIND_FAIL, rqb_pkg::TIME_MAX, 32'd2, '0, '0, '0);
    issue(rqb_pkg::KIND_FAIL, 48'd5, 32'hFFFF_FFFF, '0, '0, '0);
    issue(rqb_pkg::KIND_ACK, 48'd2000, 32'd3, '0, '0, '0);
    issue(rqb_pkg::KIND_POLL, rqb_pkg::TIME_MAX, '0, '0, '0, '0);
    drain();

    // Zero base and a lowered max bring an existing backoff down.
    write_reg(rqb_pkg::CFG_BASE, 32'd0);
    write_reg(rqb_pkg::CFG_MAX, 32'd1);
    issue(rqb_pkg::KIND_FAIL, 48'd1000, 32'd1, '0, '0, '0);
    issue(rqb_pkg::KIND_FAIL, 48'd1000, 32'd4, '0, '0, '0);
    issue(rqb_pkg::KIND_FAIL, 48'd1000, 32'd4, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 0;
        default: idle_pct = 17;
      endcase
      case (ph)
        0: begin
          write_reg(rqb_pkg::CFG_BASE, 32'd1000);
          write_reg(rqb_pkg::CFG_MAX, 32'd60000);
        end
        1: begin
          write_reg(rqb_pkg::CFG_BASE, 32'hFFFF_FFFF);
          write_reg(rqb_pkg::CFG_MAX, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(rqb_pkg::CFG_BASE, 32'd1);
          write_reg(rqb_pkg::CFG_MAX, 32'd1);
        end
        3: begin
          write_reg(rqb_pkg::CFG_BASE, 32'd3);
          write_reg(rqb_pkg::CFG_MAX, 32'h8000_0000);
        end
        default: begin
          write_reg(rqb_pkg::CFG_BASE, $urandom_range(5000));
          write_reg(rqb_pkg::CFG_MAX, $urandom);
        end
      endcase
      random_traffic(215);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rqb_pkg.sv
rtl/rqb_datapath.sv
rtl/rqb_ctrl.sv
rtl/retry_queue_with_backoff.sv
sim/retry_queue_checker.sv
sim/retry_queue_with_backoff_test.sv
